FILE: rtl/xprx_pkg.sv
package xprx_pkg;

    localparam int unsigned STACK_BYTES = 4096;
    localparam int unsigned REG_COUNT   = 16;
    localparam int unsigned SA_W        = $clog2(STACK_BYTES);
    localparam int unsigned WORD_DEPTH  = STACK_BYTES / 8;
    localparam int unsigned WA_W        = $clog2(WORD_DEPTH);
    localparam int unsigned RIDX_W      = $clog2(REG_COUNT);

    localparam logic [RIDX_W-1:0] RSP_NUM = RIDX_W'(4);
    localparam logic [RIDX_W-1:0] RBP_NUM = RIDX_W'(5);
    localparam logic [63:0] STACK_HALF = 64'(STACK_BYTES / 2);

    localparam logic [2:0] F_MOV      = 3'd0;
    localparam logic [2:0] F_XOR      = 3'd1;
    localparam logic [2:0] F_SUB      = 3'd2;
    localparam logic [2:0] F_LEA      = 3'd3;
    localparam logic [2:0] F_PUSH     = 3'd4;
    localparam logic [2:0] F_POP      = 3'd5;
    localparam logic [2:0] F_STORE_R  = 3'd6;
    localparam logic [2:0] F_STORE_I  = 3'd7;

    localparam logic [2:0] V_64 = 3'd0;
    localparam logic [2:0] V_32 = 3'd1;
    localparam logic [2:0] V_16 = 3'd2;
    localparam logic [2:0] V_L8 = 3'd3;
    localparam logic [2:0] V_H8 = 3'd4;

    localparam logic [1:0] FLT_OK     = 2'd0;
    localparam logic [1:0] FLT_WIDTH  = 2'd1;
    localparam logic [1:0] FLT_WINDOW = 2'd2;

    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  dst_reg;
        logic [2:0]  dst_view;
        logic [3:0]  src_reg;
        logic [2:0]  src_view;
        logic [3:0]  base_reg;
        logic [2:0]  base_view;
        logic [3:0]  index_reg;
        logic        has_index;
        logic [3:0]  scale;
        logic [63:0] disp;
        logic [63:0] imm;
    } t_instr;

    typedef struct packed {
        logic [1:0]  fault_code;
        logic        zero_flag;
        logic [63:0] dest_value;
        logic [63:0] eff_addr;
        logic [63:0] stack_ptr;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic mem_rd;
        logic clear;
        logic commit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clear_done;
    } t_status;

    // size in bytes (0 = bad view)
    function automatic logic [3:0] view_bytes(input logic [2:0] v);
        logic [3:0] b;
        unique case (v)
            V_64:       b = 4'd8;
            V_32:       b = 4'd4;
            V_16:       b = 4'd2;
            V_L8, V_H8: b = 4'd1;
            default:    b = 4'd0;
        endcase
        return b;
    endfunction

    function automatic logic [63:0] bytes_mask(input logic [3:0] n);
        logic [63:0] m;
        unique case (n)
            4'd8:    m = '1;
            4'd4:    m = 64'h0000_0000_FFFF_FFFF;
            4'd2:    m = 64'h0000_0000_0000_FFFF;
            4'd1:    m = 64'h0000_0000_0000_00FF;
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [63:0] rd_view(input logic [63:0] r, input logic [2:0] v,
                                            input logic [3:0] n);
        logic [63:0] t;
        t = (v == V_H8) ? (r >> 8) : r;
        return t & bytes_mask(n);
    endfunction

    function automatic logic [63:0] wr_view(input logic [63:0] r, input logic [2:0] v,
                                            input logic [63:0] val);
        logic [63:0] m;
        logic [63:0] s;
        m = bytes_mask(view_bytes(v));
        s = val;
        if (v == V_H8) begin
            m = m << 8;
            s = val << 8;
        end
        return (r & ~m) | (s & m);
    endfunction

endpackage

FILE: rtl/xprx_ram.sv
module xprx_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/xprx_ctrl.sv
module xprx_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  xprx_pkg::t_status i_status,
    output xprx_pkg::t_cmd    o_cmd
);
    import xprx_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_EXEC  = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.commit = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_commit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_out_valid && !o_cmd.commit)
        else $error("commit not followed by result");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("accept while result pending");
endmodule

FILE: rtl/xprx_dp.sv
module xprx_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xprx_pkg::t_cmd    i_cmd,
    output xprx_pkg::t_status o_status,
    input  xprx_pkg::t_instr  i_instr,
    input  logic              i_cfg_we,
    input  logic [63:0]       i_cfg_data,
    output xprx_pkg::t_result o_result
);
    import xprx_pkg::*;

    logic [63:0] r_regs [REG_COUNT];
    logic        r_zf;
    logic [63:0] r_base;
    t_instr      r_in;
    t_result     r_res;
    logic [WA_W:0] r_clr;

    // effective address and access, computed in READ, used in EXEC
    logic [63:0] r_ea;
    logic [SA_W-1:0] r_off;
    logic [3:0]  r_n;
    logic [63:0] r_val;
    logic [1:0]  r_flt;
    logic [63:0] r_ea_out;

    // decode on registered instruction
    logic [3:0]  db, sb, bb, n_acc;
    logic [63:0] base_v, idx_v, ea_calc, ea_mem, off, rsp;
    logic [1:0]  flt;
    logic [63:0] ea_shown, wval;
    logic        in_win;

    assign rsp = r_regs[RSP_NUM];

    always_comb begin
        db      = view_bytes(r_in.dst_view);
        sb      = view_bytes(r_in.src_view);
        bb      = view_bytes(r_in.base_view);
        base_v  = rd_view(r_regs[r_in.base_reg], r_in.base_view, bb);
        idx_v   = rd_view(r_regs[r_in.index_reg], V_64, bb);
        ea_calc = base_v + r_in.disp;
        if (r_in.has_index) begin
            ea_calc = ea_calc + 64'({4'd0, idx_v[31:0]} * r_in.scale)
                      + {(idx_v[63:32] * r_in.scale), 32'd0};
        end
        flt      = FLT_OK;
        ea_mem   = ea_calc;
        ea_shown = '0;
        n_acc    = '0;
        wval     = '0;
        unique case (r_in.func)
            F_MOV, F_XOR: begin
                if (db == 4'd0 || sb == 4'd0) flt = FLT_WIDTH;
            end
            F_SUB: begin
                if (db == 4'd0) flt = FLT_WIDTH;
            end
            F_LEA: begin
                if (db < 4'd2 || bb < 4'd2) flt = FLT_WIDTH;
                else ea_shown = ea_calc;
            end
            F_PUSH: begin
                n_acc  = db;
                ea_mem = rsp - 64'(db);
                wval   = rd_view(r_regs[r_in.dst_reg], r_in.dst_view, db);
                if (db < 4'd2) flt = FLT_WIDTH;
                else ea_shown = ea_mem;
            end
            F_POP: begin
                n_acc  = db;
                ea_mem = rsp;
                if (db < 4'd2) flt = FLT_WIDTH;
                else ea_shown = ea_mem;
            end
            default: begin
                n_acc = (r_in.func == F_STORE_R) ? sb : bb;
                wval  = (r_in.func == F_STORE_R)
                        ? rd_view(r_regs[r_in.src_reg], r_in.src_view, sb) : r_in.imm;
                if (n_acc < 4'd2 || bb < 4'd2) flt = FLT_WIDTH;
                else ea_shown = ea_calc;
            end
        endcase
        off    = ea_mem - r_base;
        in_win = off <= 64'(STACK_BYTES) - 64'(n_acc);
        if (flt == FLT_OK && n_acc != 4'd0 && !in_win) flt = FLT_WINDOW;
    end

    // stack memory: eight byte lanes, two word rows per access, indexed by window offset
    logic [SA_W-1:0] a_lo;
    logic [2:0]      sh;
    logic [WA_W-1:0] row0, row1;
    logic [7:0]      lane_q0 [8];
    logic [7:0]      lane_q1 [8];
    logic [127:0]    wide_w, wide_m, rd_wide;
    logic [63:0]     rd_val;
    logic            do_wr;

    assign a_lo = i_cmd.mem_rd ? off[SA_W-1:0] : r_off;
    assign sh   = a_lo[2:0];
    assign row0 = a_lo[SA_W-1:3];
    assign row1 = row0 + WA_W'(1);
    assign do_wr = i_cmd.commit && r_flt == FLT_OK && r_in.func != F_POP && r_n != 4'd0;
    assign wide_w = {64'd0, r_val} << {sh, 3'd0};
    assign wide_m = {64'd0, bytes_mask(r_n)} << {sh, 3'd0};

    for (genvar g = 0; g < 8; g++) begin : g_lane
        // lane g of row r holds byte offset 8r+g; access bytes in lanes >= sh use row0
        logic [WA_W-1:0] ra;
        logic [WA_W-1:0] wa;
        logic            we;
        logic [7:0]      wd;
        logic [7:0]      q;
        logic            hi;
        always_comb begin
            hi = 3'(g) < sh;
            ra = hi ? row1 : row0;
            if (i_cmd.clear) begin
                wa = r_clr[WA_W-1:0];
                we = 1'b1;
                wd = '0;
            end else begin
                wa = ra;
                we = do_wr && (hi ? wide_m[64+8*g] : wide_m[8*g]);
                wd = hi ? wide_w[64+8*g +: 8] : wide_w[8*g +: 8];
            end
        end
        xprx_ram #(.WIDTH(8), .DEPTH(WORD_DEPTH)) u_ram (
            .i_clk  (i_clk),
            .i_we   (we),
            .i_waddr(wa),
            .i_wdata(wd),
            .i_raddr(ra),
            .o_rdata(q)
        );
        assign lane_q0[g] = hi ? 8'd0 : q;
        assign lane_q1[g] = hi ? q : 8'd0;
    end

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            rd_wide[8*k +: 8]      = lane_q0[k];
            rd_wide[64+8*k +: 8]   = lane_q1[k];
        end
        rd_val = 64'(rd_wide >> {sh, 3'd0}) & bytes_mask(r_n);
    end

    // commit
    logic [63:0] nregs [REG_COUNT];
    logic        nzf;
    logic [63:0] s, subr, rspn;

    always_comb begin
        for (int k = 0; k < REG_COUNT; k++) nregs[k] = r_regs[k];
        nzf  = r_zf;
        s    = rd_view(r_regs[r_in.src_reg], (r_in.src_view == V_H8) ? V_H8 : V_64, db);
        subr = (rd_view(r_regs[r_in.dst_reg], r_in.dst_view, db) - r_in.imm) & bytes_mask(db);
        rspn = '0;
        if (r_flt == FLT_OK) begin
            unique case (r_in.func)
                F_MOV: nregs[r_in.dst_reg] = wr_view(r_regs[r_in.dst_reg], r_in.dst_view, s);
                F_XOR: nregs[r_in.dst_reg] = wr_view(r_regs[r_in.dst_reg], r_in.dst_view,
                           s ^ rd_view(r_regs[r_in.dst_reg], r_in.dst_view, db));
                F_SUB: begin
                    nregs[r_in.dst_reg] = wr_view(r_regs[r_in.dst_reg], r_in.dst_view, subr);
                    nzf = (subr == 64'd0);
                end
                F_LEA: nregs[r_in.dst_reg] = wr_view(r_regs[r_in.dst_reg], r_in.dst_view, r_ea);
                F_PUSH: nregs[RSP_NUM] = r_ea;
                F_POP: begin
                    rspn = r_ea + 64'(r_n);
                    nregs[RSP_NUM] = rspn;
                    if (r_in.dst_reg == RSP_NUM) begin
                        nregs[RSP_NUM] = wr_view(rspn, r_in.dst_view, rd_val);
                    end else begin
                        nregs[r_in.dst_reg] = wr_view(r_regs[r_in.dst_reg], r_in.dst_view,
                                                      rd_val);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < REG_COUNT; k++) r_regs[k] <= '0;
            r_regs[RSP_NUM] <= STACK_HALF;
            r_regs[RBP_NUM] <= STACK_HALF;
            r_zf   <= 1'b0;
            r_base <= '0;
            r_clr  <= '0;
        end else begin
            if (i_cmd.clear) r_clr <= r_clr + (WA_W+1)'(1);
            if (i_cfg_we) begin
                r_base          <= i_cfg_data;
                r_regs[RSP_NUM] <= i_cfg_data + STACK_HALF;
                r_regs[RBP_NUM] <= i_cfg_data + STACK_HALF;
            end else if (i_cmd.commit) begin
                for (int k = 0; k < REG_COUNT; k++) r_regs[k] <= nregs[k];
                r_zf <= nzf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_instr;
        if (i_cmd.mem_rd) begin
            r_ea     <= ea_mem;
            r_off    <= off[SA_W-1:0];
            r_n      <= n_acc;
            r_val    <= wval;
            r_flt    <= flt;
            r_ea_out <= ea_shown;
        end
        if (i_cmd.commit) begin
            r_res.fault_code <= r_flt;
            r_res.zero_flag  <= nzf;
            r_res.dest_value <= nregs[r_in.dst_reg];
            r_res.eff_addr   <= r_ea_out;
            r_res.stack_ptr  <= nregs[RSP_NUM];
        end
    end

    assign o_status.clear_done = (r_clr == (WA_W+1)'(WORD_DEPTH - 1));
    assign o_result = r_res;

    a_clr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr <= (WA_W+1)'(WORD_DEPTH))
        else $error("clear counter overran");
    a_fault_keeps_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && r_flt != FLT_OK && !i_cfg_we |=> $stable(r_regs[RSP_NUM]))
        else $error("faulted step moved rsp");
    a_no_wr_on_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_wr |-> r_flt == FLT_OK)
        else $error("store on fault");
endmodule

FILE: rtl/x86_64_partial_register_exec_unit.sv
// Executes one decoded instruction per request on sixteen 64-bit registers with
// 64/32/16/low8/high8 views and a STACK_BYTES byte stack memory (eight byte-wide
// RAM lanes). After reset a clearing pass over all STACK_BYTES/8 rows zeroes the
// stack before the first request is taken. Each request is then loaded, decoded
// and addressed with the RAM read issued, and committed, and its result is held
// until it is taken; one request is in flight at a time.
module x86_64_partial_register_exec_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [63:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // func[2:0] dst_reg[6:3] dst_view[9:7] src_reg[13:10] src_view[16:14]
    // base_reg[20:17] base_view[23:21] index_reg[27:24] has_index[28]
    // scale[32:29] disp[96:33] imm[160:97], zero fill to 168
    input  logic [167:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // fault_code[1:0] zero_flag[2] dest_value[66:3] eff_addr[130:67]
    // stack_ptr[194:131], zero fill to 200
    output logic [199:0] m_axis_tdata
);
    import xprx_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_instr  instr;
    t_result res;

    assign instr.func      = s_axis_tdata[2:0];
    assign instr.dst_reg   = s_axis_tdata[6:3];
    assign instr.dst_view  = s_axis_tdata[9:7];
    assign instr.src_reg   = s_axis_tdata[13:10];
    assign instr.src_view  = s_axis_tdata[16:14];
    assign instr.base_reg  = s_axis_tdata[20:17];
    assign instr.base_view = s_axis_tdata[23:21];
    assign instr.index_reg = s_axis_tdata[27:24];
    assign instr.has_index = s_axis_tdata[28];
    assign instr.scale     = s_axis_tdata[32:29];
    assign instr.disp      = s_axis_tdata[96:33];
    assign instr.imm       = s_axis_tdata[160:97];

    xprx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    xprx_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_status  (status),
        .i_instr   (instr),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .o_result  (res)
    );

    assign m_axis_tdata = {5'd0, res.stack_ptr, res.eff_addr, res.dest_value,
                           res.zero_flag, res.fault_code};
endmodule
